[src/jseu_pkg.sv]
// ----------------------------------------------------------------------------
// jseu_pkg
// Types, constants and helper functions shared by the JSON string escaper
// with UTF-8 checking.
// ----------------------------------------------------------------------------
package jseu_pkg;

    // ascii codes used in the escaped literal
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;

    // control bytes with short escapes
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF = 8'h0a;
    localparam logic [7:0] CTL_FF = 8'h0c;
    localparam logic [7:0] CTL_CR = 8'h0d;
    localparam logic [7:0] CTL_LIMIT = 8'h20;

    // utf-8 lead and continuation bounds
    localparam logic [7:0] U8_ASCII_END = 8'h80;
    localparam logic [7:0] U8_CONT_MAX  = 8'hbf;
    localparam logic [7:0] U8_LEAD2_MIN = 8'hc2;
    localparam logic [7:0] U8_LEAD2_MAX = 8'hdf;
    localparam logic [7:0] U8_LEAD3_MIN = 8'he0;
    localparam logic [7:0] U8_LEAD3_MAX = 8'hef;
    localparam logic [7:0] U8_LEAD4_MIN = 8'hf0;
    localparam logic [7:0] U8_LEAD4_MAX = 8'hf4;
    localparam logic [7:0] U8_LEAD_ED   = 8'hed;
    localparam logic [7:0] U8_SPLIT_A0  = 8'ha0;
    localparam logic [7:0] U8_SPLIT_90  = 8'h90;

    // body lengths of the escape forms
    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_CTRL  = 3'd6;

    // range rule for the byte after a three or four byte lead
    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,
        RULE_E0   = 3'd1,
        RULE_ED   = 3'd2,
        RULE_F0   = 3'd3,
        RULE_F4   = 3'd4
    } t_rule;

    // input item fields
    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
        logic       last_byte;
        logic       empty_string;
    } t_in_item;

    // input item plus the utf-8 verdict for its closing quote
    typedef struct packed {
        t_in_item   fields;
        logic       utf8_error;
    } t_item;

    // short escape letter, zero when the byte has none
    function automatic logic [7:0] short_code(input logic [7:0] b);
        logic [7:0] code;
        code = 8'h00;
        unique case (b)
            CH_QUOTE:     code = CH_QUOTE;
            CH_BACKSLASH: code = CH_BACKSLASH;
            CTL_BS:       code = CH_B;
            CTL_FF:       code = CH_F;
            CTL_LF:       code = CH_N;
            CTL_CR:       code = CH_R;
            CTL_TAB:      code = CH_T;
            default:      code = 8'h00;
        endcase
        return code;
    endfunction

    // lower-case hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10) begin
            d = CH_ZERO + {4'd0, n};
        end else begin
            d = CH_LOWER_A + {4'd0, n} - 8'd10;
        end
        return d;
    endfunction

endpackage

[src/jseu_utf8_chk.sv]
// ----------------------------------------------------------------------------
// jseu_utf8_chk
// Strict UTF-8 checker; updates its state on every accepted item and gives
// the verdict that goes with the closing quote of that item.
// ----------------------------------------------------------------------------
module jseu_utf8_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  jseu_pkg::t_in_item i_item,
    output logic               o_utf8_error
);

    logic [1:0]      r_pend, n_pend;
    jseu_pkg::t_rule r_rule, n_rule;
    logic            r_mal,  n_mal;

    logic [1:0]      c_pend;
    jseu_pkg::t_rule c_rule;
    logic            c_mal;
    logic            bad;
    logic [7:0]      b;

    // next checker state for the offered item
    always_comb begin
        b      = i_item.byte_value;
        c_pend = i_item.first_byte ? 2'd0 : r_pend;
        c_rule = i_item.first_byte ? jseu_pkg::RULE_NONE : r_rule;
        c_mal  = i_item.first_byte ? 1'b0 : r_mal;
        bad    = 1'b0;
        n_pend = c_pend;
        n_rule = jseu_pkg::RULE_NONE;
        n_mal  = c_mal;
        o_utf8_error = 1'b0;

        if (c_pend != 2'd0) begin
            // continuation byte
            bad = (b < jseu_pkg::U8_ASCII_END) || (b > jseu_pkg::U8_CONT_MAX);
            unique case (c_rule)
                jseu_pkg::RULE_E0: if (b < jseu_pkg::U8_SPLIT_A0) bad = 1'b1;
                jseu_pkg::RULE_ED: if (b >= jseu_pkg::U8_SPLIT_A0) bad = 1'b1;
                jseu_pkg::RULE_F0: if (b < jseu_pkg::U8_SPLIT_90) bad = 1'b1;
                jseu_pkg::RULE_F4: if (b >= jseu_pkg::U8_SPLIT_90) bad = 1'b1;
                default: ;
            endcase
            n_mal  = c_mal | bad;
            n_pend = c_pend - 2'd1;
        end else if (b < jseu_pkg::U8_ASCII_END) begin
            n_pend = 2'd0;
        end else if (b >= jseu_pkg::U8_LEAD2_MIN && b <= jseu_pkg::U8_LEAD2_MAX) begin
            n_pend = 2'd1;
        end else if (b >= jseu_pkg::U8_LEAD3_MIN && b <= jseu_pkg::U8_LEAD3_MAX) begin
            n_pend = 2'd2;
            if (b == jseu_pkg::U8_LEAD3_MIN) begin
                n_rule = jseu_pkg::RULE_E0;
            end else if (b == jseu_pkg::U8_LEAD_ED) begin
                n_rule = jseu_pkg::RULE_ED;
            end
        end else if (b >= jseu_pkg::U8_LEAD4_MIN && b <= jseu_pkg::U8_LEAD4_MAX) begin
            n_pend = 2'd3;
            if (b == jseu_pkg::U8_LEAD4_MIN) begin
                n_rule = jseu_pkg::RULE_F0;
            end else if (b == jseu_pkg::U8_LEAD4_MAX) begin
                n_rule = jseu_pkg::RULE_F4;
            end
        end else begin
            n_mal = 1'b1;
        end

        // string end: verdict out, state cleared
        if (i_item.empty_string) begin
            n_pend = 2'd0;
            n_rule = jseu_pkg::RULE_NONE;
            n_mal  = 1'b0;
        end else if (i_item.last_byte) begin
            o_utf8_error = n_mal | (n_pend != 2'd0);
            n_pend = 2'd0;
            n_rule = jseu_pkg::RULE_NONE;
            n_mal  = 1'b0;
        end
    end

    // checker state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_rule <= jseu_pkg::RULE_NONE;
            r_mal  <= 1'b0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_rule <= n_rule;
            r_mal  <= n_mal;
        end
    end

endmodule

[src/jseu_emit.sv]
// ----------------------------------------------------------------------------
// jseu_emit
// Holds one item and walks its escaped result bytes into an output register,
// one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module jseu_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  jseu_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last,
    output logic            o_string_end,
    output logic            o_utf8_error
);

    logic            r_item_valid;
    jseu_pkg::t_item r_item;
    logic [2:0]      r_idx;

    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;
    logic            r_string_end;
    logic            r_utf8_error;

    logic [7:0]      b;
    logic [7:0]      code;
    logic            has_open;
    logic            has_close;
    logic [2:0]      body_len;
    logic [3:0]      total;
    logic [2:0]      j;
    logic            res_last;
    logic [7:0]      n_byte;
    logic            n_end;
    logic            n_err;
    logic            out_load;
    logic            item_done;
    logic            accept;

    // result byte at the current index of the held item
    always_comb begin
        b         = r_item.fields.byte_value;
        code      = jseu_pkg::short_code(b);
        has_open  = r_item.fields.first_byte | r_item.fields.empty_string;
        has_close = r_item.fields.last_byte | r_item.fields.empty_string;
        if (r_item.fields.empty_string) begin
            body_len = 3'd0;
        end else if (code != 8'h00) begin
            body_len = jseu_pkg::LEN_SHORT;
        end else if (b < jseu_pkg::CTL_LIMIT) begin
            body_len = jseu_pkg::LEN_CTRL;
        end else begin
            body_len = jseu_pkg::LEN_PLAIN;
        end
        total    = {3'd0, has_open} + {1'b0, body_len} + {3'd0, has_close};
        res_last = (({1'b0, r_idx} + 4'd1) == total);
        j        = r_idx - {2'd0, has_open};
        n_end    = 1'b0;
        n_err    = 1'b0;
        n_byte   = jseu_pkg::CH_QUOTE;

        if (has_open && r_idx == 3'd0) begin
            n_byte = jseu_pkg::CH_QUOTE;
        end else if (j < body_len) begin
            if (code != 8'h00) begin
                n_byte = (j == 3'd0) ? jseu_pkg::CH_BACKSLASH : code;
            end else if (b < jseu_pkg::CTL_LIMIT) begin
                unique case (j)
                    3'd0:    n_byte = jseu_pkg::CH_BACKSLASH;
                    3'd1:    n_byte = jseu_pkg::CH_U;
                    3'd2:    n_byte = jseu_pkg::CH_ZERO;
                    3'd3:    n_byte = jseu_pkg::CH_ZERO;
                    3'd4:    n_byte = jseu_pkg::hex_digit(b[7:4]);
                    default: n_byte = jseu_pkg::hex_digit(b[3:0]);
                endcase
            end else begin
                n_byte = b;
            end
        end else begin
            // closing quote
            n_byte = jseu_pkg::CH_QUOTE;
            n_end  = 1'b1;
            n_err  = r_item.utf8_error;
        end
    end

    // handshake between item register and output register
    assign out_load  = r_item_valid && (!r_out_valid || i_ready);
    assign item_done = out_load && res_last;
    assign o_ready   = !r_item_valid || item_done;
    assign accept    = i_valid && o_ready;

    // held item and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_idx        <= 3'd0;
        end else if (accept) begin
            r_item_valid <= 1'b1;
            r_idx        <= 3'd0;
        end else if (item_done) begin
            r_item_valid <= 1'b0;
            r_idx        <= 3'd0;
        end else if (out_load) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte   <= n_byte;
            r_out_last   <= res_last;
            r_string_end <= n_end;
            r_utf8_error <= n_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_string_end = r_string_end;
    assign o_utf8_error = r_utf8_error;

endmodule

[src/json_string_escape_utf8_check_unit.sv]
// Path: an accepted item is held in the item register and its results leave through the output register.
// Throughput: one result per cycle while the output is not stalled; an item has
// 1 to 8 results, set by the single output register walking the escape bytes.
// An item with one result sustains one item per cycle while the output is not stalled.
// Reset: synchronous active-low; clears the UTF-8 checker state and all valids.
// ----------------------------------------------------------------------------
// json_string_escape_utf8_check_unit
// Byte-serial JSON string literal escaper with strict UTF-8 validation; the
// verdict is flagged on the closing quote.
// ----------------------------------------------------------------------------
module json_string_escape_utf8_check_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_value,
    input  logic       i_first_byte,
    input  logic       i_last_byte,
    input  logic       i_empty_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_string_end,
    output logic       o_utf8_error
);

    jseu_pkg::t_in_item in_item;
    jseu_pkg::t_item    item;
    logic               accept;
    logic               chk_err;

    // gather input fields
    assign in_item.byte_value   = i_byte_value;
    assign in_item.first_byte   = i_first_byte;
    assign in_item.last_byte    = i_last_byte;
    assign in_item.empty_string = i_empty_string;
    assign accept               = i_in_valid && o_in_ready;

    // utf-8 check runs on accept, verdict travels with the item
    jseu_utf8_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (in_item),
        .o_utf8_error (chk_err)
    );

    assign item.fields     = in_item;
    assign item.utf8_error = chk_err;

    // escape byte sequencer
    jseu_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (item),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_string_end (o_string_end),
        .o_utf8_error (o_utf8_error)
    );

endmodule

[src/jseu_checker.sv]
// ----------------------------------------------------------------------------
// jseu_checker
// Port-level assertions for the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
module jseu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic       o_string_end,
    input logic       o_utf8_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_out_last) && $stable(o_string_end) && $stable(o_utf8_error))
        else $error("stalled result changed");

    // error flag only on the closing quote
    a_err_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_utf8_error |-> o_string_end)
        else $error("utf8 error outside closing quote");

    // closing quote is always the last result of its item and is a quote
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_end |-> o_out_last && (o_out_byte == jseu_pkg::CH_QUOTE))
        else $error("closing quote malformed");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind json_string_escape_utf8_check_unit jseu_checker u_jseu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_out_last   (o_out_last),
    .o_string_end (o_string_end),
    .o_utf8_error (o_utf8_error)
);
